// ----- design/bds_pkg.sv -----
`timescale 1ns / 1ps

package bds_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int HEIGHT_CAP = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int X_W        = $clog2(LINE_DEPTH);
  localparam int COL_W      = X_W + 1;
  localparam int ROW_W      = $clog2(HEIGHT_CAP);
  localparam int DIM_W      = 13;
  localparam int CNT_CH_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_LANES  = 4;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 1;
  localparam int TOT_W      = PIX_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // per-pixel decisions from the position counters
  typedef struct packed {
    logic                 load_hold;
    logic                 use_hold;
    logic                 wr_line;
    logic                 rd_line;
    logic                 emit;
    logic                 last;
    logic [1:0]           shift;
    logic [X_W-1:0]       x;
    logic [NUM_LANES-1:0] lane_en;
  } step_t;

  typedef struct packed {
    logic       load_hold;
    logic       use_hold;
    logic       take;
    logic       use_line;
    logic [1:0] shift;
  } lane_ctl_t;

endpackage

// ----- design/box_downscale_2x2.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | in_tdata: chan_r, chan_g, chan_b, chan_a
// out_    | out | out_tvalid/tready  | out_tdata: out_r..out_a, out_tlast: last_pixel
// cfg_    | in  | cfg_we             | cfg_addr index, cfg_wdata value
//
// One source pixel per cycle unless the output stalls; after the transfer of the
// pixel that completes a block, its result passes stage one (pair register and
// registered line-buffer read), then the output register. Synchronous reset
// clears counters and valid flags; the line buffer is not cleared, each entry is
// written on an even row before the odd row reads it. in_tready drops only when
// stage one and the output register are both full and out_tready is low.

module box_downscale_2x2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // chan_r, chan_g, chan_b, chan_a
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // out_r, out_g, out_b, out_a
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bds_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int NL = bds_pkg::NUM_LANES;
  localparam int PW = bds_pkg::PIX_W;
  localparam int SW = bds_pkg::SUM_W;

  bds_pkg::step_t     step;
  bds_pkg::lane_ctl_t lane_ctl;

  logic accept, s1_go;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_use_line_r, s1_last_r;
  logic [1:0] s1_shift_r;
  logic out_valid_r, out_last_r;
  logic [NL*PW-1:0] out_data_r;

  logic [NL*SW-1:0] line_wdata, line_rdata;
  logic [NL*PW-1:0] lane_res;

  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  bds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .step      (step)
  );

  always_comb begin
    lane_ctl.load_hold = step.load_hold;
    lane_ctl.use_hold  = step.use_hold;
    lane_ctl.take      = accept && step.emit;
    lane_ctl.use_line  = s1_use_line_r;
    lane_ctl.shift     = s1_shift_r;
  end

  for (genvar k = 0; k < NL; k++) begin : g_lane
    bds_lane u_lane (
      .clk      (clk),
      .accept   (accept),
      .lane_en  (step.lane_en[k]),
      .pix      (in_tdata[k*PW +: PW]),
      .ctl      (lane_ctl),
      .line_sum (line_rdata[k*SW +: SW]),
      .pair_sum (line_wdata[k*SW +: SW]),
      .result   (lane_res[k*PW +: PW])
    );
  end

  bds_ram #(
    .WIDTH (NL * SW),
    .DEPTH (bds_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && step.wr_line),
    .waddr (step.x),
    .wdata (line_wdata),
    .re    (accept && step.rd_line),
    .raddr (step.x),
    .rdata (line_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept && step.emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.emit) begin
      s1_use_line_r <= step.rd_line;
      s1_shift_r    <= step.shift;
      s1_last_r     <= step.last;
    end
    // merge lane results into the output register
    if (s1_go && s1_valid_r) begin
      out_data_r <= lane_res;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/bds_ram.sv -----
`timescale 1ns / 1ps

module bds_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/bds_ctrl.sv -----
`timescale 1ns / 1ps

module bds_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bds_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          accept,
  output bds_pkg::step_t                step
);

  localparam int DW = bds_pkg::DIM_W;
  localparam int CW = bds_pkg::COL_W;
  localparam int RW = bds_pkg::ROW_W;

  logic [DW-1:0]                width_r, width_nxt;
  logic [DW-1:0]                height_r, height_nxt;
  logic [bds_pkg::CNT_CH_W-1:0] chans_r, chans_nxt;
  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;

  logic w1, h1, col_ok, row_ok, chan_ok, active, have_pair, last_x, last_y, restart;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                              input logic [DW-1:0] cap);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (v > cap) begin
      res = cap;
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_comb begin
    w1      = width_r > DW'(1);
    h1      = height_r > DW'(1);
    // a trailing odd column or row has no partner
    col_ok  = !w1 || (CW'(col_r >> 1) != CW'(width_r >> 1));
    row_ok  = !h1 || (RW'(row_r >> 1) != RW'(height_r >> 1));
    last_x  = !w1 || (CW'(col_r >> 1) == CW'((width_r >> 1) - DW'(1)));
    last_y  = !h1 || (RW'(row_r >> 1) == RW'((height_r >> 1) - DW'(1)));
    chan_ok = (chans_r >= bds_pkg::CNT_CH_W'(1)) &&
              (chans_r <= bds_pkg::CNT_CH_W'(bds_pkg::NUM_LANES));
    active    = chan_ok && (w1 || h1) && col_ok && row_ok;
    have_pair = active && (!w1 || col_r[0]);

    step.load_hold = active && w1 && !col_r[0];
    step.use_hold  = w1;
    step.wr_line   = have_pair && h1 && !row_r[0];
    step.rd_line   = have_pair && h1 && row_r[0];
    step.emit      = have_pair && (!h1 || row_r[0]);
    step.last      = last_x && last_y;
    step.shift     = {1'b0, w1} + {1'b0, h1};
    step.x         = w1 ? col_r[CW-1:1] : '0;
    for (int k = 0; k < bds_pkg::NUM_LANES; k++) begin
      step.lane_en[k] = bds_pkg::CNT_CH_W'(k) < chans_r;
    end
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    chans_nxt  = chans_r;
    restart    = 1'b0;
    if (cfg_we) begin
      case (cfg_addr)
        bds_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = clamp_dim(cfg_wdata, DW'(bds_pkg::MAX_WIDTH));
          restart   = 1'b1;
        end
        bds_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = clamp_dim(cfg_wdata, DW'(bds_pkg::HEIGHT_CAP));
          restart    = 1'b1;
        end
        bds_pkg::REG_CHANNEL_COUNT: begin
          chans_nxt = cfg_wdata[bds_pkg::CNT_CH_W-1:0];
          restart   = 1'b1;
        end
        default: begin
        end
      endcase
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      // advance raster position, wrap at frame end
      if (DW'(col_r) + DW'(1) >= width_r) begin
        col_nxt = '0;
        if (DW'(row_r) + DW'(1) >= height_r) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(1);
      height_r <= DW'(1);
      chans_r  <= bds_pkg::CNT_CH_W'(bds_pkg::NUM_LANES);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      chans_r  <= chans_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ----- design/bds_lane.sv -----
`timescale 1ns / 1ps

module bds_lane (
  input  logic                      clk,
  input  logic                      accept,
  input  logic                      lane_en,
  input  logic [bds_pkg::PIX_W-1:0] pix,
  input  bds_pkg::lane_ctl_t        ctl,
  input  logic [bds_pkg::SUM_W-1:0] line_sum,
  output logic [bds_pkg::SUM_W-1:0] pair_sum,
  output logic [bds_pkg::PIX_W-1:0] result
);

  logic [bds_pkg::PIX_W-1:0] pix_m;
  logic [bds_pkg::PIX_W-1:0] hold_r;
  logic [bds_pkg::SUM_W-1:0] pair_r;
  logic [bds_pkg::TOT_W-1:0] tot;
  logic [bds_pkg::TOT_W-1:0] mean;

  assign pix_m    = lane_en ? pix : '0;
  assign pair_sum = ctl.use_hold ? ({1'b0, hold_r} + {1'b0, pix_m}) : {1'b0, pix_m};

  always_ff @(posedge clk) begin
    if (accept && ctl.load_hold) begin
      hold_r <= pix_m;
    end
    if (ctl.take) begin
      pair_r <= pair_sum;
    end
  end

  // finish the block with the even-row pair from the line buffer
  assign tot    = bds_pkg::TOT_W'(pair_r) +
                  (ctl.use_line ? bds_pkg::TOT_W'(line_sum) : '0);
  assign mean   = tot >> ctl.shift;
  assign result = mean[bds_pkg::PIX_W-1:0];

endmodule

// ----- design/bds_checker.sv -----
`timescale 1ns / 1ps

module bds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // a fresh result follows an input transfer through stage one and the output register
  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without matching input transfer");

  // input is held off only by output backpressure
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

endmodule

bind box_downscale_2x2 bds_checker u_bds_checker (.*);
